### rtl/aosd_pkg.sv
package aosd_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int TIME_WIDTH   = 32;
    localparam logic [1:0] DEFAULT_QUADRANT = 2'd3;

    localparam int IN_DATA_W  = ((3 * SAMPLE_WIDTH + TIME_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = 8;

    localparam int TILT_W = 15;
    localparam int BOUND_W = 32;
    localparam int LIMIT_W = 4;
    localparam int STABLE_W = 16;

    localparam int SQ_W   = 2 * SAMPLE_WIDTH;
    localparam int MSQ_W  = 2 * SAMPLE_WIDTH + 2;
    localparam int CMP_W  = (MSQ_W > BOUND_W) ? MSQ_W : BOUND_W;
    localparam int TCMP_W = (SAMPLE_WIDTH > TILT_W) ? SAMPLE_WIDTH : TILT_W;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    localparam logic [TILT_W-1:0]   RST_TILT       = 15'd4096;
    localparam logic [BOUND_W-1:0]  RST_UPPER_SQ   = 32'd141097387;
    localparam logic [BOUND_W-1:0]  RST_LOWER_SQ   = 32'd20300431;
    localparam logic [LIMIT_W-1:0]  RST_HIT_LIMIT  = 4'd3;
    localparam logic [STABLE_W-1:0] RST_STABLE     = 16'd300;
    localparam logic                RST_ROTATION   = 1'b1;

    typedef enum logic [2:0] {
        REG_TILT      = 3'd0,
        REG_UPPER_SQ  = 3'd1,
        REG_LOWER_SQ  = 3'd2,
        REG_HIT_LIMIT = 3'd3,
        REG_STABLE    = 3'd4,
        REG_ROTATION  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [TILT_W-1:0]   flat_level;
        logic [BOUND_W-1:0]  shake_upper_sq;
        logic [BOUND_W-1:0]  shake_lower_sq;
        logic [LIMIT_W-1:0]  shake_hit_limit;
        logic [STABLE_W-1:0] hold_ms;
        logic                rot_en;
    } t_cfg;

    typedef struct packed {
        logic                  op;
        logic                  shake;
        logic                  flat;
        logic [1:0]            target;
        logic [TIME_WIDTH-1:0] now;
    } t_feat;

endpackage

### rtl/aosd_regs.sv
module aosd_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [aosd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [aosd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [aosd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output aosd_pkg::t_cfg                   o_cfg
);

    aosd_pkg::t_cfg r_cfg;
    logic [2:0] idx;
    logic wr;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flat_level      <= aosd_pkg::RST_TILT;
            r_cfg.shake_upper_sq  <= aosd_pkg::RST_UPPER_SQ;
            r_cfg.shake_lower_sq  <= aosd_pkg::RST_LOWER_SQ;
            r_cfg.shake_hit_limit <= aosd_pkg::RST_HIT_LIMIT;
            r_cfg.hold_ms         <= aosd_pkg::RST_STABLE;
            r_cfg.rot_en          <= aosd_pkg::RST_ROTATION;
        end else if (wr) begin
            case (idx)
                aosd_pkg::REG_TILT:      r_cfg.flat_level <= pwdata[aosd_pkg::TILT_W-1:0];
                aosd_pkg::REG_UPPER_SQ:  r_cfg.shake_upper_sq <= pwdata[aosd_pkg::BOUND_W-1:0];
                aosd_pkg::REG_LOWER_SQ:  r_cfg.shake_lower_sq <= pwdata[aosd_pkg::BOUND_W-1:0];
                aosd_pkg::REG_HIT_LIMIT: r_cfg.shake_hit_limit <= pwdata[aosd_pkg::LIMIT_W-1:0];
                aosd_pkg::REG_STABLE:    r_cfg.hold_ms <= pwdata[aosd_pkg::STABLE_W-1:0];
                aosd_pkg::REG_ROTATION:  r_cfg.rot_en <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            aosd_pkg::REG_TILT:      prdata[aosd_pkg::TILT_W-1:0] = r_cfg.flat_level;
            aosd_pkg::REG_UPPER_SQ:  prdata = r_cfg.shake_upper_sq;
            aosd_pkg::REG_LOWER_SQ:  prdata = r_cfg.shake_lower_sq;
            aosd_pkg::REG_HIT_LIMIT: prdata[aosd_pkg::LIMIT_W-1:0] = r_cfg.shake_hit_limit;
            aosd_pkg::REG_STABLE:    prdata[aosd_pkg::STABLE_W-1:0] = r_cfg.hold_ms;
            aosd_pkg::REG_ROTATION:  prdata[0] = r_cfg.rot_en;
            default: prdata = '0;
        endcase
    end

endmodule

### rtl/aosd_front.sv
module aosd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic                                i_op,
    input  logic [aosd_pkg::IN_DATA_W-1:0]      i_data,
    input  aosd_pkg::t_cfg                      i_cfg,
    output logic                                o_feat_valid,
    output aosd_pkg::t_feat                     o_feat
);

    localparam int SW = aosd_pkg::SAMPLE_WIDTH;
    localparam int TW = aosd_pkg::TIME_WIDTH;

    logic                 r_a_valid;
    logic                 r_a_op;
    logic signed [SW-1:0] r_a_x, r_a_y, r_a_z;
    logic [TW-1:0]        r_a_now;

    logic [SW-1:0] ax, ay, az;
    logic          flat;
    logic [1:0]    target;
    logic          x_pos, y_pos;

    logic                    r_b_valid;
    logic                    r_b_op;
    logic [aosd_pkg::SQ_W-1:0] r_b_sx, r_b_sy, r_b_sz;
    logic                    r_b_flat;
    logic [1:0]              r_b_target;
    logic [TW-1:0]           r_b_now;

    logic [aosd_pkg::CMP_W-1:0] msq;
    logic                       shake;

    logic            r_c_valid;
    aosd_pkg::t_feat r_c_feat;

    assign ax = r_a_x[SW-1] ? SW'(-r_a_x) : SW'(r_a_x);
    assign ay = r_a_y[SW-1] ? SW'(-r_a_y) : SW'(r_a_y);
    assign az = r_a_z[SW-1] ? SW'(-r_a_z) : SW'(r_a_z);

    assign x_pos = !r_a_x[SW-1] && (r_a_x != '0);
    assign y_pos = !r_a_y[SW-1] && (r_a_y != '0);

    assign flat = (aosd_pkg::TCMP_W'(ax) < aosd_pkg::TCMP_W'(i_cfg.flat_level))
               && (aosd_pkg::TCMP_W'(ay) < aosd_pkg::TCMP_W'(i_cfg.flat_level));

    always_comb begin
        if (ay > ax) begin
            target = y_pos ? 2'd3 : 2'd1;
        end else begin
            target = x_pos ? 2'd0 : 2'd2;
        end
    end

    assign msq = aosd_pkg::CMP_W'(r_b_sx) + aosd_pkg::CMP_W'(r_b_sy)
               + aosd_pkg::CMP_W'(r_b_sz);
    assign shake = (msq > aosd_pkg::CMP_W'(i_cfg.shake_upper_sq))
                || (msq < aosd_pkg::CMP_W'(i_cfg.shake_lower_sq));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_op  <= i_op;
            r_a_x   <= i_data[SW-1:0];
            r_a_y   <= i_data[2*SW-1:SW];
            r_a_z   <= i_data[3*SW-1:2*SW];
            r_a_now <= i_data[3*SW+TW-1:3*SW];

            r_b_op     <= r_a_op;
            r_b_sx     <= aosd_pkg::SQ_W'(ax) * aosd_pkg::SQ_W'(ax);
            r_b_sy     <= aosd_pkg::SQ_W'(ay) * aosd_pkg::SQ_W'(ay);
            r_b_sz     <= aosd_pkg::SQ_W'(az) * aosd_pkg::SQ_W'(az);
            r_b_flat   <= flat;
            r_b_target <= target;
            r_b_now    <= r_a_now;

            r_c_feat.op     <= r_b_op;
            r_c_feat.shake  <= shake;
            r_c_feat.flat   <= r_b_flat;
            r_c_feat.target <= r_b_target;
            r_c_feat.now    <= r_b_now;
        end
    end

    assign o_feat_valid = r_c_valid;
    assign o_feat       = r_c_feat;

endmodule

### rtl/aosd_state.sv
module aosd_state (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_feat_valid,
    input  aosd_pkg::t_feat  i_feat,
    input  aosd_pkg::t_cfg   i_cfg,
    output logic             o_valid,
    output logic [1:0]       o_quadrant,
    output logic             o_taken,
    output logic             o_pending
);

    localparam int TW = aosd_pkg::TIME_WIDTH;
    localparam int LW = aosd_pkg::LIMIT_W;

    logic [1:0]    r_cur, r_cand;
    logic [TW-1:0] r_start;
    logic [LW-1:0] r_hits;
    logic          r_latch;
    logic          r_valid;
    logic [1:0]    r_quadrant;
    logic          r_taken, r_pending;

    logic [1:0]    n_cur, n_cand;
    logic [TW-1:0] n_start;
    logic [LW-1:0] n_hits, hits_up;
    logic          n_latch, n_taken;
    logic [TW-1:0] elapsed;

    assign elapsed = i_feat.now - r_start;
    assign hits_up = (r_hits < i_cfg.shake_hit_limit) ? r_hits + LW'(1) : r_hits;

    always_comb begin
        n_cur   = r_cur;
        n_cand  = r_cand;
        n_start = r_start;
        n_hits  = r_hits;
        n_latch = r_latch;
        n_taken = 1'b0;
        if (i_feat.op == aosd_pkg::OP_CONSUME) begin
            n_taken = r_latch;
            n_latch = 1'b0;
        end else begin
            if (i_feat.shake) begin
                n_hits = hits_up;
                if (hits_up >= i_cfg.shake_hit_limit) begin
                    n_latch = 1'b1;
                end
            end else if (r_hits != '0) begin
                n_hits = r_hits - LW'(1);
            end

            if (!i_cfg.rot_en || i_feat.flat || i_feat.target == r_cur) begin
                n_cand = r_cur;
            end else if (i_feat.target != r_cand) begin
                n_cand  = i_feat.target;
                n_start = i_feat.now;
            end else if (elapsed >= TW'(i_cfg.hold_ms)) begin
                n_cur = i_feat.target;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= aosd_pkg::DEFAULT_QUADRANT;
            r_cand  <= aosd_pkg::DEFAULT_QUADRANT;
            r_start <= '0;
            r_hits  <= '0;
            r_latch <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_feat_valid;
            if (i_feat_valid) begin
                r_cur   <= n_cur;
                r_cand  <= n_cand;
                r_start <= n_start;
                r_hits  <= n_hits;
                r_latch <= n_latch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_feat_valid) begin
            r_quadrant <= n_cur;
            r_taken    <= n_taken;
            r_pending  <= n_latch;
        end
    end

    assign o_valid    = r_valid;
    assign o_quadrant = r_quadrant;
    assign o_taken    = r_taken;
    assign o_pending  = r_pending;

endmodule

### rtl/accel_orientation_and_shake_detect_core.sv
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser: operation; tdata: x, y, z, time_ms
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: quadrant, shake_taken, shake_pending
// apb       in         psel/penable/pready           six registers at 4*index, on a 32-bit data bus
//
// One beat is accepted per cycle unless the output stalls; beats overlap in the pipeline.
// The pipeline is input register, squaring stage, magnitude compare stage and state update.
// The whole pipeline advances together; it stalls only while a result waits at the output.
// Reset is synchronous and active low and restores the default quadrant and register values.
module accel_orientation_and_shake_detect_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: accel_x, accel_y, accel_z, time_ms.
    input  logic [aosd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // Fields from bit 0: operation.
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0: quadrant, shake_taken, shake_pending, zero fill.
    output logic [aosd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [aosd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [aosd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [aosd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    aosd_pkg::t_cfg  cfg;
    aosd_pkg::t_feat feat;
    logic            feat_valid;
    logic            en;
    logic [1:0]      quadrant;
    logic            taken, pending;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tdata  = {{(aosd_pkg::OUT_DATA_W - 4){1'b0}}, pending, taken, quadrant};

    aosd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    aosd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (s_axis_tvalid),
        .i_op         (s_axis_tuser),
        .i_data       (s_axis_tdata),
        .i_cfg        (cfg),
        .o_feat_valid (feat_valid),
        .o_feat       (feat)
    );

    aosd_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_feat_valid (feat_valid),
        .i_feat       (feat),
        .i_cfg        (cfg),
        .o_valid      (m_axis_tvalid),
        .o_quadrant   (quadrant),
        .o_taken      (taken),
        .o_pending    (pending)
    );

    a_consume_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && taken) |-> !pending)
        else $error("shake latch still pending after it was taken");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input held off without an output stall");

    a_flat_data_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(quadrant))
        else $error("quadrant changed while the result was stalled");

endmodule
